// ----- design/b64e_pkg.sv -----
package b64e_pkg;

    localparam logic [6:0] PAD_CODE    = 7'd61;
    localparam int         QUEUE_DEPTH = 2;

    // one byte of the message on the input channel
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    // one encoded character on the result channel
    typedef struct packed {
        logic [6:0] char_code;
        logic       last_char;
    } out_word_t;

    // a complete or flushed group handed from front to back
    typedef struct packed {
        logic [23:0] triple;
        logic [1:0]  nbytes;
        logic        last;
    } group_t;

    // queue occupancy seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // map a sextet to its character in the standard alphabet
    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        logic [6:0] code;
        code = 7'd0;
        if (v < 6'd26) begin
            code = 7'd65 + {1'b0, v};
        end else if (v < 6'd52) begin
            code = 7'd97 + {1'b0, v} - 7'd26;
        end else if (v < 6'd62) begin
            code = 7'd48 + {1'b0, v} - 7'd52;
        end else if (v == 6'd62) begin
            code = 7'd43;
        end else begin
            code = 7'd47;
        end
        return code;
    endfunction

endpackage

// ----- design/b64e_front.sv -----
module b64e_front import b64e_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  in_word_t      s_data,
    input  queue_status_t q_status,
    output logic          push,
    output group_t        push_group
);

    logic [1:0]  count_reg, count_next;
    logic [15:0] held_reg,  held_next;
    logic        completes;
    logic        accept;

    // a byte closes a group on the third byte or on the message end
    assign completes = s_data.last_byte || (count_reg == 2'd2);
    assign s_ready   = !completes || !q_status.full;
    assign accept    = s_valid && s_ready;
    assign push      = accept && completes;

    always_comb begin
        count_next = count_reg;
        held_next  = held_reg;
        push_group = '0;
        case (count_reg)
            2'd1: begin
                push_group.triple = {held_reg[15:8], s_data.data_byte, 8'h00};
                push_group.nbytes = 2'd2;
            end
            2'd2: begin
                push_group.triple = {held_reg, s_data.data_byte};
                push_group.nbytes = 2'd3;
            end
            default: begin
                push_group.triple = {s_data.data_byte, 16'h0000};
                push_group.nbytes = 2'd1;
            end
        endcase
        push_group.last = s_data.last_byte;
        if (accept) begin
            if (completes) begin
                count_next = 2'd0;
                held_next  = 16'h0000;
            end else if (count_reg == 2'd1) begin
                count_next = 2'd2;
                held_next  = {held_reg[15:8], s_data.data_byte};
            end else begin
                count_next = 2'd1;
                held_next  = {s_data.data_byte, 8'h00};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
            held_reg  <= 16'h0000;
        end else begin
            count_reg <= count_next;
            held_reg  <= held_next;
        end
    end

endmodule

// ----- design/b64e_queue.sv -----
module b64e_queue import b64e_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  group_t        push_group,
    input  logic          pop,
    output group_t        head_group,
    output queue_status_t q_status
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    group_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   fill_reg,   fill_next;

    assign q_status.full  = (fill_reg == CNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (fill_reg == '0);
    assign head_group     = entry_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_group;
        end
    end

endmodule

// ----- design/b64e_back.sv -----
module b64e_back import b64e_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  group_t        head_group,
    input  queue_status_t q_status,
    output logic          pop,
    output logic          m_valid,
    input  logic          m_ready,
    output out_word_t     m_data
);

    group_t     group_reg,  group_next;
    logic       busy_reg,   busy_next;
    logic [1:0] idx_reg,    idx_next;
    logic       valid_reg,  valid_next;
    out_word_t  data_reg,   data_next;
    logic       advance;
    logic [5:0] sextet;
    logic       is_pad;

    // emit a character whenever the output register is free or drains
    assign advance = busy_reg && (!valid_reg || m_ready);
    assign pop     = !q_status.empty && (!busy_reg || (advance && idx_reg == 2'd3));

    always_comb begin
        case (idx_reg)
            2'd0:    sextet = group_reg.triple[23:18];
            2'd1:    sextet = group_reg.triple[17:12];
            2'd2:    sextet = group_reg.triple[11:6];
            default: sextet = group_reg.triple[5:0];
        endcase
        is_pad = ((idx_reg == 2'd2) && (group_reg.nbytes < 2'd2))
              || ((idx_reg == 2'd3) && (group_reg.nbytes < 2'd3));

        valid_next = valid_reg;
        data_next  = data_reg;
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        group_next = group_reg;

        if (valid_reg && m_ready) begin
            valid_next = 1'b0;
        end
        if (advance) begin
            valid_next          = 1'b1;
            data_next.char_code = is_pad ? PAD_CODE : sextet_char(sextet);
            data_next.last_char = (idx_reg == 2'd3) && group_reg.last;
            idx_next            = idx_reg + 2'd1;
            if (idx_reg == 2'd3) begin
                busy_next = 1'b0;
            end
        end
        if (pop) begin
            group_next = head_group;
            busy_next  = 1'b1;
            idx_next   = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        group_reg <= group_next;
        data_reg  <= data_next;
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// ----- design/base64_encoder.sv -----
// Streaming base64 encoder, standard alphabet with '=' padding. Feed one
// message byte per word on the s_ side with last_byte set on the final byte;
// the m_ side returns one ASCII character per word, four for every group of
// three bytes, and a message ending mid-group is zero-filled and padded
// ("==" after one leftover byte, "=" after two). last_char marks the final
// character of the message. A byte that does not close a group is always
// taken and produces nothing; a closing byte is taken as soon as the
// two-entry group queue has room. The output side writes one character per
// cycle while m_ready allows, four for every group, so the character
// serializer in the back end limits the input rate; the queue lets the byte
// side run ahead by two groups.
module base64_encoder import b64e_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic          push;
    group_t        push_group;
    logic          pop;
    group_t        head_group;
    queue_status_t q_status;

    // gather bytes into groups and hand finished groups to the queue
    b64e_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .q_status   (q_status),
        .push       (push),
        .push_group (push_group)
    );

    // hold up to two groups so either side can stall alone
    b64e_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_group (push_group),
        .pop        (pop),
        .head_group (head_group),
        .q_status   (q_status)
    );

    // turn each group into four characters, one per cycle while the output is not stalled
    b64e_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_group (head_group),
        .q_status   (q_status),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// ----- design/b64e_checker.sv -----
module b64e_checker import b64e_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_word_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    logic [1:0] pos_reg;

    // track the character position within its group of four
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= 2'd0;
        end else if (m_valid && m_ready) begin
            pos_reg <= pos_reg + 2'd1;
        end
    end

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input word changed while stalled");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_last_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.last_char |-> pos_reg == 2'd3)
        else $error("final character not at end of group");

    a_pad_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.char_code == PAD_CODE |-> pos_reg == 2'd2 || pos_reg == 2'd3)
        else $error("pad character in a data position");

endmodule

bind base64_encoder b64e_checker u_b64e_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- verif/base64_encoder_checker.sv -----
`timescale 1ns / 100ps

module base64_encoder_checker import b64e_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_word_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_word_t m_data,
    output int        mismatch_count,
    output int        chars_pending,
    output int        chars_checked
);

    localparam logic [8*64-1:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam logic [6:0] EQ_SIGN = 7'd61;

    out_word_t   expected_chars[$];
    logic [15:0] held_bytes;
    logic [1:0]  group_count;
    int          reported;

    function automatic logic [6:0] alpha_code(input logic [5:0] sextet);
        logic [7:0] ch;
        ch = B64_ALPHABET[8*(63 - sextet) +: 8];
        return ch[6:0];
    endfunction

    // queue four characters for one 24-bit group with nbytes real bytes
    task automatic emit_group(input logic [23:0] triple, input int nbytes,
                              input logic is_last);
        out_word_t w;
        w.last_char = 1'b0;
        w.char_code = alpha_code(triple[23:18]);
        expected_chars.push_back(w);
        w.char_code = alpha_code(triple[17:12]);
        expected_chars.push_back(w);
        w.char_code = (nbytes >= 2) ? alpha_code(triple[11:6]) : EQ_SIGN;
        expected_chars.push_back(w);
        w.char_code = (nbytes >= 3) ? alpha_code(triple[5:0]) : EQ_SIGN;
        w.last_char = is_last;
        expected_chars.push_back(w);
    endtask

    task automatic predict_byte(input in_word_t w);
        logic [1:0] count;
        count = (group_count == 2'd3) ? 2'd0 : group_count;
        case (count)
            2'd0: begin
                if (!w.last_byte) begin
                    held_bytes  = {w.data_byte, 8'h00};
                    group_count = 2'd1;
                    return;
                end
                emit_group({w.data_byte, 16'h0000}, 1, 1'b1);
            end
            2'd1: begin
                if (!w.last_byte) begin
                    held_bytes  = {held_bytes[15:8], w.data_byte};
                    group_count = 2'd2;
                    return;
                end
                emit_group({held_bytes[15:8], w.data_byte, 8'h00}, 2, 1'b1);
            end
            default: begin
                emit_group({held_bytes, w.data_byte}, 3, w.last_byte);
            end
        endcase
        held_bytes  = 16'h0000;
        group_count = 2'd0;
    endtask

    always @(posedge aclk) begin
        out_word_t exp_w;
        if (!aresetn) begin
            held_bytes     = 16'h0000;
            group_count    = 2'd0;
            mismatch_count = 0;
            chars_checked  = 0;
            reported       = 0;
            expected_chars.delete();
        end else begin
            if (s_valid && s_ready) begin
                predict_byte(s_data);
            end
            if (m_valid && m_ready) begin
                chars_checked = chars_checked + 1;
                if (expected_chars.size() == 0) begin
                    mismatch_count = mismatch_count + 1;
                    if (reported < 10) begin
                        reported = reported + 1;
                        $display("[%0t] unexpected char: code=%0d last=%0b", $realtime,
                                 m_data.char_code, m_data.last_char);
                    end
                end else begin
                    exp_w = expected_chars.pop_front();
                    if (exp_w.char_code !== m_data.char_code ||
                        exp_w.last_char !== m_data.last_char) begin
                        mismatch_count = mismatch_count + 1;
                        if (reported < 10) begin
                            reported = reported + 1;
                            $display("[%0t] char mismatch: exp code=%0d last=%0b,",
                                     $realtime, exp_w.char_code, exp_w.last_char,
                                     " got code=%0d last=%0b",
                                     m_data.char_code, m_data.last_char);
                        end
                    end
                end
            end
        end
        chars_pending = expected_chars.size();
    end

endmodule

// ----- verif/base64_encoder_tb.sv -----
`timescale 1ns / 100ps

module base64_encoder_tb;
    import b64e_pkg::*;

    // abort if nothing moves on either channel for this many cycles
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_BYTES  = 500;
    localparam int DRAIN_CYCLES  = 16;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    int mismatch_count;
    int chars_pending;
    int chars_checked;

    // idling control: off during the no-gap stretch
    logic sender_gaps;
    logic receiver_gaps;

    int bytes_sent;
    int messages_sent;
    int tail_count[3];
    int quiet_cycles;

    base64_encoder dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    base64_encoder_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .mismatch_count (mismatch_count),
        .chars_pending  (chars_pending),
        .chars_checked  (chars_checked)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // Receiver: drop ready in roughly a third of the cycles while gaps are on,
    // otherwise hold it high. Changes land on the falling edge.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (receiver_gaps) begin
            m_ready <= ($urandom_range(99) >= 32);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: count cycles with no word moving on either side.
    always @(posedge aclk) begin
        if (!aresetn) begin
            quiet_cycles <= 0;
        end else if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
            $display("base64_encoder verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one byte and return at the rising edge where it is taken.
    // Valid stays high until that edge; the next call (or drop_valid) moves
    // it at the following falling edge, so it is never toggled within a step.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        @(negedge aclk);
        while (sender_gaps && $urandom_range(99) < 32) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_data.data_byte <= b;
        s_data.last_byte <= is_last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent = bytes_sent + 1;
    endtask

    task automatic drop_valid();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // Send a message of n bytes packed MSB first in msg.
    task automatic send_message(input logic [8*6-1:0] msg, input int n);
        for (int i = 0; i < n; i++) begin
            send_byte(msg[8*(n-1-i) +: 8], i == n - 1);
        end
        messages_sent = messages_sent + 1;
        tail_count[n % 3] = tail_count[n % 3] + 1;
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(15);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    task automatic send_random_message();
        int sel;
        int len;
        sel = $urandom_range(9);
        if (sel < 7) begin
            len = $urandom_range(1, 6);
        end else if (sel < 9) begin
            len = $urandom_range(7, 20);
        end else begin
            len = $urandom_range(21, 48);
        end
        for (int i = 0; i < len; i++) begin
            send_byte(pick_byte(), i == len - 1);
        end
        messages_sent = messages_sent + 1;
        tail_count[len % 3] = tail_count[len % 3] + 1;
    endtask

    initial begin
        int random_start;
        int pause_done;

        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        m_ready       = 1'b0;
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
        bytes_sent    = 0;
        messages_sent = 0;
        tail_count[0] = 0;
        tail_count[1] = 0;
        tail_count[2] = 0;
        pause_done    = 0;

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: known vectors, full and partial last groups, extreme bytes,
        // and the '+' and '/' characters.
        send_message(48'h4D616E, 3);       // "Man" -> TWFu
        send_message(48'h4D61, 2);         // "Ma"  -> TWE=
        send_message(48'h4D, 1);           // "M"   -> TQ==
        send_message(48'h00, 1);           // lone zero byte, two pads
        send_message(48'hFF, 1);           // lone 0xFF, two pads
        send_message(48'hFFFF, 2);         // one pad, all-ones
        send_message(48'h000000, 3);       // full group of zeros ends message
        send_message(48'hFFFFFF, 3);       // "////"
        send_message(48'hFBEFBE, 3);       // "++++"
        send_message(48'h0102FFFE, 4);     // group then a one-byte tail

        // Hold off until the encoder has drained everything.
        drop_valid();
        wait (chars_pending == 0);

        // Random messages; a no-gap stretch in the middle, a drain pause once.
        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            if (bytes_sent - random_start >= 200 && bytes_sent - random_start < 320) begin
                sender_gaps   = 1'b0;
                receiver_gaps = 1'b0;
            end else begin
                sender_gaps   = 1'b1;
                receiver_gaps = 1'b1;
            end
            if (!pause_done && bytes_sent - random_start >= 380) begin
                drop_valid();
                wait (chars_pending == 0);
                pause_done = 1;
            end
            send_random_message();
        end
        drop_valid();
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;

        // Drain, then keep watching for DRAIN_CYCLES to show stray output.
        wait (chars_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d bytes in %0d messages", bytes_sent, messages_sent,
                 " (tails: %0d full, %0d one-byte, %0d two-byte)",
                 tail_count[0], tail_count[1], tail_count[2]);
        $display("checked %0d characters, %0d mismatches", chars_checked, mismatch_count);
        if (mismatch_count == 0 && chars_pending == 0) begin
            $display("base64_encoder verification clean");
        end else begin
            $display("base64_encoder verification failed");
        end
        $finish;
    end

endmodule
